// ----- rtl/shcd_pkg.sv -----
// Shared register map, register widths and reset values for the clipping distortion.
package shcd_pkg;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_PRE_GAIN    = 3'd0,
    CFG_DRIVE_GAIN  = 3'd1,
    CFG_WET_MIX     = 3'd2,
    CFG_SOFT_ENABLE = 3'd3,
    CFG_HARD_ENABLE = 3'd4
  } cfg_idx_t;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 17;

  localparam int PRE_GAIN_W   = 16;
  localparam int DRIVE_GAIN_W = 15;
  localparam int WET_MIX_W    = 17;

  localparam logic [PRE_GAIN_W-1:0]   PRE_GAIN_RST   = 16'd4915;  // about 1.2 in Q4.12
  localparam logic [DRIVE_GAIN_W-1:0] DRIVE_GAIN_RST = 15'd307;
  localparam logic [WET_MIX_W-1:0]    WET_MIX_RST    = 17'd32768;

  // Wet fraction of one in Q1.16.
  localparam logic [WET_MIX_W-1:0] MIX_FULL = 17'd65536;

  // Cycles through the exponential lookup and interpolation unit.
  localparam int EXP_LAT = 3;

endpackage

// ----- rtl/soft_hard_clip_distortion.sv -----
// Top level: gain, soft and hard clipping, and dry/wet mix in a nine-stage pipeline.
//
//   channel  ports                               handshake
//   input    start, busy, in_sample              beat taken when start and not busy
//   result   out_valid, out_sample               one-cycle strobe, no back-pressure
//   config   cfg_wr_en, cfg_index, cfg_wdata     write on any edge with cfg_wr_en
//
// One beat enters per clock; busy is always low. Each result is registered through
// the stages in order: two gain multiplies, the magnitude, the table read,
// interpolation multiply and rounding, clipping, the mix multiplies and saturation.
// Synchronous active-low reset clears the valid bits and restores the register
// defaults. The receiver cannot stall, so no stage ever holds.
module soft_hard_clip_distortion
  import shcd_pkg::*;
#(
  parameter int SAMPLE_BITS     = 24,
  parameter int EXP_TABLE_DEPTH = 256   // power of two
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  output logic                          out_valid,
  output logic signed [SAMPLE_BITS-1:0] out_sample,
  input  logic                          cfg_wr_en,
  input  logic [CFG_INDEX_W-1:0]        cfg_index,
  input  logic [CFG_DATA_W-1:0]         cfg_wdata
);

  localparam int FRAC     = SAMPLE_BITS - 1;
  localparam int P1_W     = SAMPLE_BITS + 17;
  localparam int DRY_W    = SAMPLE_BITS + 5;
  localparam int P2_W     = SAMPLE_BITS + 21;
  localparam int WET_W    = SAMPLE_BITS + 13;
  localparam int MW_W     = WET_W + 18;
  localparam int MD_W     = DRY_W + 18;
  localparam int ACC_W    = WET_W + 19;
  localparam int Y_W      = ACC_W - 16;
  localparam int PIPE_LAT = 6 + EXP_LAT;

  localparam logic signed [P1_W-1:0]  RND12    = P1_W'(2048);
  localparam logic signed [P2_W-1:0]  RND8     = P2_W'(128);
  localparam logic signed [ACC_W-1:0] RND16    = ACC_W'(32768);
  localparam logic signed [WET_W-1:0] WET_ONE  = WET_W'(1) << FRAC;
  localparam logic signed [WET_W-1:0] WET_MONE = -WET_ONE;
  localparam logic signed [Y_W-1:0]   Y_MAX    = (Y_W'(1) << FRAC) - Y_W'(1);
  localparam logic signed [Y_W-1:0]   Y_MIN    = -(Y_W'(1) << FRAC);

  // Configuration registers.
  logic [PRE_GAIN_W-1:0]   pre_gain_r;
  logic [DRIVE_GAIN_W-1:0] drive_gain_r;
  logic [WET_MIX_W-1:0]    wet_mix_r;
  logic                    soft_enable_r;
  logic                    hard_enable_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pre_gain_r    <= PRE_GAIN_RST;
      drive_gain_r  <= DRIVE_GAIN_RST;
      wet_mix_r     <= WET_MIX_RST;
      soft_enable_r <= 1'b1;
      hard_enable_r <= 1'b1;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_PRE_GAIN:    pre_gain_r    <= cfg_wdata[PRE_GAIN_W-1:0];
        CFG_DRIVE_GAIN:  drive_gain_r  <= cfg_wdata[DRIVE_GAIN_W-1:0];
        CFG_WET_MIX:     wet_mix_r     <= cfg_wdata[WET_MIX_W-1:0];
        CFG_SOFT_ENABLE: soft_enable_r <= cfg_wdata[0];
        CFG_HARD_ENABLE: hard_enable_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // The pipeline takes a beat in every cycle.
  logic in_fire;
  assign busy    = 1'b0;
  assign in_fire = start && !busy;

  logic v1_r, v2_r, v3_r, v7_r, v8_r, v9_r;
  logic exp_valid;
  logic [SAMPLE_BITS-1:0] exp_val;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v7_r <= 1'b0;
      v8_r <= 1'b0;
      v9_r <= 1'b0;
    end else begin
      v1_r <= in_fire;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v7_r <= exp_valid;
      v8_r <= v7_r;
      v9_r <= v8_r;
    end
  end

  // Stage one: pre-gain multiply.
  logic signed [P1_W-1:0] p1_r;
  always_ff @(posedge clk) begin
    p1_r <= in_sample * $signed({1'b0, pre_gain_r});
  end

  // Stage two: round to the dry signal, then apply the drive gain.
  logic signed [P1_W-1:0]  p1_rnd;
  logic signed [DRY_W-1:0] dry1;
  logic signed [DRY_W-1:0] dry2_r;
  logic signed [P2_W-1:0]  p2_r;
  assign p1_rnd = p1_r + RND12;
  assign dry1   = p1_rnd[P1_W-1:12];

  always_ff @(posedge clk) begin
    dry2_r <= dry1;
    p2_r   <= dry1 * $signed({1'b0, drive_gain_r});
  end

  // Stage three: pick the wet signal and take its magnitude for the table.
  logic signed [P2_W-1:0]  p2_rnd;
  logic signed [WET_W-1:0] wet_sel3;
  logic [WET_W-1:0]        mag3_r;
  logic signed [WET_W-1:0] wet3_r;
  logic signed [DRY_W-1:0] dry3_r;
  assign p2_rnd   = p2_r + RND8;
  assign wet_sel3 = (soft_enable_r || hard_enable_r) ? p2_rnd[P2_W-1:8]
                  : {{(WET_W-DRY_W){dry2_r[DRY_W-1]}}, dry2_r};

  always_ff @(posedge clk) begin
    wet3_r <= wet_sel3;
    dry3_r <= dry2_r;
    mag3_r <= wet_sel3[WET_W-1] ? WET_W'(-wet_sel3) : WET_W'(wet_sel3);
  end

  shcd_exp_interp #(
    .SAMPLE_BITS     (SAMPLE_BITS),
    .EXP_TABLE_DEPTH (EXP_TABLE_DEPTH)
  ) u_exp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v3_r),
    .in_mag    (mag3_r),
    .out_valid (exp_valid),
    .out_exp   (exp_val)
  );

  // Delay the wet and dry values across the lookup unit.
  logic signed [WET_W-1:0] wet_dly_r [EXP_LAT];
  logic signed [DRY_W-1:0] dry_dly_r [EXP_LAT];
  always_ff @(posedge clk) begin
    wet_dly_r[0] <= wet3_r;
    dry_dly_r[0] <= dry3_r;
    for (int i = 1; i < EXP_LAT; i++) begin
      wet_dly_r[i] <= wet_dly_r[i-1];
      dry_dly_r[i] <= dry_dly_r[i-1];
    end
  end

  // Stage seven: soft clip from the exponential, then the hard limit, each when enabled.
  logic signed [WET_W-1:0] wet_in7;
  logic signed [WET_W-1:0] exp_ext;
  logic signed [WET_W-1:0] soft7;
  logic signed [WET_W-1:0] shaped7;
  logic signed [WET_W-1:0] wet7_r;
  logic signed [DRY_W-1:0] dry7_r;
  assign wet_in7 = wet_dly_r[EXP_LAT-1];
  assign exp_ext = WET_W'(exp_val);
  assign soft7   = (wet_in7 > 0) ? (WET_ONE - exp_ext) : (exp_ext - WET_ONE);

  always_comb begin
    shaped7 = soft_enable_r ? soft7 : wet_in7;
    if (hard_enable_r) begin
      if (shaped7 > WET_ONE) begin
        shaped7 = WET_ONE;
      end else if (shaped7 < WET_MONE) begin
        shaped7 = WET_MONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    wet7_r <= shaped7;
    dry7_r <= dry_dly_r[EXP_LAT-1];
  end

  // Stage eight: weight the wet and dry paths.
  logic [WET_MIX_W-1:0]   mix_m;
  logic [WET_MIX_W-1:0]   mix_d;
  logic signed [MW_W-1:0] mw8_r;
  logic signed [MD_W-1:0] md8_r;
  assign mix_m = (wet_mix_r > MIX_FULL) ? MIX_FULL : wet_mix_r;
  assign mix_d = MIX_FULL - mix_m;

  always_ff @(posedge clk) begin
    mw8_r <= wet7_r * $signed({1'b0, mix_m});
    md8_r <= dry7_r * $signed({1'b0, mix_d});
  end

  // Stage nine: sum, round and saturate to the sample width.
  logic signed [ACC_W-1:0]       acc9;
  logic signed [Y_W-1:0]         y9;
  logic signed [SAMPLE_BITS-1:0] y_sat;
  logic signed [SAMPLE_BITS-1:0] out_r;
  assign acc9 = ACC_W'(mw8_r) + ACC_W'(md8_r) + RND16;
  assign y9   = acc9[ACC_W-1:16];

  always_comb begin
    if (y9 > Y_MAX) begin
      y_sat = SAMPLE_BITS'(Y_MAX);
    end else if (y9 < Y_MIN) begin
      y_sat = SAMPLE_BITS'(Y_MIN);
    end else begin
      y_sat = SAMPLE_BITS'(y9);
    end
  end

  always_ff @(posedge clk) begin
    out_r <= y_sat;
  end

  assign out_valid  = v9_r;
  assign out_sample = out_r;

  // Every accepted beat comes out exactly once, after the pipeline latency.
  a_beat_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |-> ##PIPE_LAT out_valid)
    else $error("accepted beat did not reach the output on time");

  a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_fire, PIPE_LAT))
    else $error("result strobe without a matching input beat");

  // The interpolated exponential never exceeds one.
  a_exp_range: assert property (@(posedge clk) disable iff (!rst_n)
    exp_valid |-> (exp_val <= (SAMPLE_BITS'(1) << FRAC)))
    else $error("exponential lookup out of range");

endmodule

// ----- rtl/shcd_exp_interp.sv -----
// Pipelined exp(-a) lookup with linear interpolation over a constant table.
module shcd_exp_interp
  import shcd_pkg::*;
#(
  parameter int SAMPLE_BITS     = 24,
  parameter int EXP_TABLE_DEPTH = 256
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic [SAMPLE_BITS+12:0]   in_mag,
  output logic                      out_valid,
  output logic [SAMPLE_BITS-1:0]    out_exp
);

  localparam int FRAC     = SAMPLE_BITS - 1;
  localparam int MAG_W    = SAMPLE_BITS + 13;
  localparam int IDX_W    = $clog2(EXP_TABLE_DEPTH);
  localparam int ROM_AW   = $clog2(EXP_TABLE_DEPTH + 1);
  localparam int LOG_STEP = FRAC + 4 - IDX_W;
  localparam int PROD_W   = 31 + LOG_STEP;
  localparam int SHIFT_D  = 30 - FRAC;
  localparam logic [63:0] ONE30 = 64'd1 << 30;
  localparam logic [63:0] H30   = (64'd1 << 34) / EXP_TABLE_DEPTH;
  localparam logic [PROD_W-1:0] HALF_STEP = PROD_W'(1) << (LOG_STEP - 1);

  typedef logic [30:0] rom_t [EXP_TABLE_DEPTH+1];

  // Table entry k is exp(-h)^k in Q30; exp(-h) comes from a truncated Taylor sum.
  function automatic rom_t build_rom();
    rom_t        tab;
    logic [63:0] term;
    logic [63:0] pos;
    logic [63:0] neg;
    logic [63:0] r;
    term = ONE30;
    pos  = ONE30;
    neg  = 64'd0;
    for (int n = 1; n <= 12; n++) begin
      term = ((term * H30) >> 30) / 64'(n);
      if ((n & 1) != 0) begin
        neg = neg + term;
      end else begin
        pos = pos + term;
      end
    end
    r = pos - neg;
    tab[0] = 31'(ONE30);
    for (int k = 1; k <= EXP_TABLE_DEPTH; k++) begin
      tab[k] = 31'((64'(tab[k-1]) * r + (ONE30 >> 1)) >> 30);
    end
    return tab;
  endfunction

  localparam rom_t EXP_ROM = build_rom();

  logic                  v1_r, v2_r, v3_r;
  logic [30:0]           t0_r, t1_r, t0b_r;
  logic [LOG_STEP-1:0]   frac_r;
  logic                  big1_r, big2_r;
  logic [PROD_W-1:0]     prod_r;
  logic [SAMPLE_BITS-1:0] exp_r;

  logic [IDX_W-1:0]      idx;
  logic [ROM_AW-1:0]     addr0, addr1;
  logic                  big;
  logic [PROD_W-1:0]     step_sum;
  logic [30:0]           delta;
  logic [30:0]           e30;
  logic [SAMPLE_BITS-1:0] e_fit;

  // Split the magnitude into a table index and an interpolation fraction.
  assign big   = (in_mag[MAG_W-1:FRAC+4] != '0);
  assign idx   = in_mag[FRAC+3:LOG_STEP];
  assign addr0 = ROM_AW'(idx);
  assign addr1 = ROM_AW'(idx) + ROM_AW'(1);

  // Valid bits for the three stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  // Stage one: read both neighboring table entries.
  always_ff @(posedge clk) begin
    t0_r   <= EXP_ROM[addr0];
    t1_r   <= EXP_ROM[addr1];
    frac_r <= in_mag[LOG_STEP-1:0];
    big1_r <= big;
  end

  // Stage two: scale the entry difference by the fraction.
  always_ff @(posedge clk) begin
    prod_r <= PROD_W'(t0_r - t1_r) * PROD_W'(frac_r);
    t0b_r  <= t0_r;
    big2_r <= big1_r;
  end

  // Stage three: finish the interpolation and round to the sample format.
  assign step_sum = prod_r + HALF_STEP;
  assign delta    = step_sum[PROD_W-1:LOG_STEP];
  assign e30      = t0b_r - delta;

  generate
    if (SHIFT_D > 0) begin : g_round
      logic [31:0] e_sum;
      assign e_sum = {1'b0, e30} + (32'd1 << (SHIFT_D - 1));
      assign e_fit = SAMPLE_BITS'(e_sum >> SHIFT_D);
    end else if (SHIFT_D == 0) begin : g_same
      assign e_fit = SAMPLE_BITS'(e30);
    end else begin : g_widen
      assign e_fit = SAMPLE_BITS'({e30, {(-SHIFT_D){1'b0}}});
    end
  endgenerate

  always_ff @(posedge clk) begin
    exp_r <= big2_r ? '0 : e_fit;
  end

  assign out_valid = v3_r;
  assign out_exp   = exp_r;

endmodule

// ----- test/shcd_checker.sv -----
// Checker for the clipping distortion: tracks the registers, predicts each output beat, compares.
`timescale 1ns / 1ps

module shcd_checker
  import shcd_pkg::*;
#(
  parameter int SAMPLE_BITS     = 24,
  parameter int EXP_TABLE_DEPTH = 256
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic                          busy,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  input  logic                          out_valid,
  input  logic signed [SAMPLE_BITS-1:0] out_sample,
  input  logic                          cfg_wr_en,
  input  logic [CFG_INDEX_W-1:0]        cfg_index,
  input  logic [CFG_DATA_W-1:0]         cfg_wdata,
  output int                            fail_count,
  output int                            pending_count
);

  localparam int FRAC = SAMPLE_BITS - 1;
  localparam longint unsigned EXP_STEP = (64'd16 << FRAC) / EXP_TABLE_DEPTH;
  localparam longint unsigned EXP_H30  = (64'd16 << 30) / EXP_TABLE_DEPTH;
  localparam longint unsigned ONE30    = 64'd1 << 30;
  localparam int ALIGN_SHIFT = 30 - FRAC;

  // Local copy of the register file.
  logic [PRE_GAIN_W-1:0]   pre_gain_q;
  logic [DRIVE_GAIN_W-1:0] drive_gain_q;
  logic [WET_MIX_W-1:0]    wet_mix_q;
  logic                    soft_en_q;
  logic                    hard_en_q;

  // Samples of exp(-a) in Q30 over a in [0,16].
  longint unsigned decay_lut [0:EXP_TABLE_DEPTH];

  logic [SAMPLE_BITS-1:0] expected_mix_q [$];
  logic [SAMPLE_BITS-1:0] want;

  // Build the table from a truncated Taylor sum for one step, then repeated products.
  initial begin
    longint unsigned term, pos, neg, ratio;
    term = ONE30;
    pos  = ONE30;
    neg  = 0;
    for (int n = 1; n <= 12; n++) begin
      term = ((term * EXP_H30) >> 30) / longint'(n);
      if (n % 2 == 1) begin
        neg += term;
      end else begin
        pos += term;
      end
    end
    ratio = pos - neg;
    decay_lut[0] = ONE30;
    for (int k = 1; k <= EXP_TABLE_DEPTH; k++) begin
      decay_lut[k] = (decay_lut[k-1] * ratio + (ONE30 >> 1)) >> 30;
    end
  end

  // Round to nearest with ties toward plus infinity, then drop n bits.
  function automatic longint round_shift(longint v, int n);
    return (v + (longint'(1) <<< (n - 1))) >>> n;
  endfunction

  // exp(-a) in the sample's fraction format, by table lookup and interpolation.
  function automatic longint exp_decay(longint unsigned a);
    longint unsigned idx, frac, t0, t1, e30;
    if (a >= EXP_STEP * EXP_TABLE_DEPTH) begin
      return 0;
    end
    idx  = a / EXP_STEP;
    frac = a % EXP_STEP;
    t0   = decay_lut[idx];
    t1   = decay_lut[idx + 1];
    e30  = t0 - ((t0 - t1) * frac + EXP_STEP / 2) / EXP_STEP;
    if (ALIGN_SHIFT > 0) begin
      return longint'((e30 + (64'd1 << (ALIGN_SHIFT - 1))) >> ALIGN_SHIFT);
    end else if (ALIGN_SHIFT < 0) begin
      return longint'(e30 << (-ALIGN_SHIFT));
    end
    return longint'(e30);
  endfunction

  // Gain, clipping and dry/wet mix of one input sample under the current registers.
  function automatic logic [SAMPLE_BITS-1:0] predict_mix(logic signed [SAMPLE_BITS-1:0] smp);
    longint x, one, dry, wet, m, acc, y;
    one = longint'(1) <<< FRAC;
    x   = smp;
    dry = round_shift(x * longint'(pre_gain_q), 12);
    wet = dry;
    if (soft_en_q || hard_en_q) begin
      wet = round_shift(wet * longint'(drive_gain_q), 8);
    end
    if (soft_en_q) begin
      if (wet > 0) begin
        wet = one - exp_decay(wet);
      end else begin
        wet = exp_decay(-wet) - one;
      end
    end
    if (hard_en_q) begin
      if (wet > one) wet = one;
      if (wet < -one) wet = -one;
    end
    // Wet fractions above one act as fully wet.
    m = (wet_mix_q > MIX_FULL) ? longint'(MIX_FULL) : longint'(wet_mix_q);
    acc = wet * m + dry * (longint'(MIX_FULL) - m);
    y = round_shift(acc, 16);
    if (y > one - 1) y = one - 1;
    if (y < -one) y = -one;
    return y[SAMPLE_BITS-1:0];
  endfunction

  task automatic report_mismatch(string msg);
    $display("%0t ns: %s", $time, msg);
    fail_count++;
  endtask

  // Output beats are checked first, then the input beat is predicted with the
  // registers as they were before any write at the same edge.
  always @(posedge clk) begin
    if (!rst_n) begin
      pre_gain_q   = PRE_GAIN_RST;
      drive_gain_q = DRIVE_GAIN_RST;
      wet_mix_q    = WET_MIX_RST;
      soft_en_q    = 1'b1;
      hard_en_q    = 1'b1;
      expected_mix_q.delete();
    end else begin
      if (out_valid) begin
        if (expected_mix_q.size() == 0) begin
          report_mismatch($sformatf("output beat %0d with nothing outstanding",
                                    $signed(out_sample)));
        end else begin
          want = expected_mix_q.pop_front();
          if (out_sample !== want) begin
            report_mismatch($sformatf("out_sample got %0d, want %0d",
                                      $signed(out_sample), $signed(want)));
          end
        end
      end
      if (start && !busy) begin
        expected_mix_q.push_back(predict_mix(in_sample));
      end
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_PRE_GAIN:    pre_gain_q   = cfg_wdata[PRE_GAIN_W-1:0];
          CFG_DRIVE_GAIN:  drive_gain_q = cfg_wdata[DRIVE_GAIN_W-1:0];
          CFG_WET_MIX:     wet_mix_q    = cfg_wdata[WET_MIX_W-1:0];
          CFG_SOFT_ENABLE: soft_en_q    = cfg_wdata[0];
          CFG_HARD_ENABLE: hard_en_q    = cfg_wdata[0];
          default: ;
        endcase
      end
    end
    pending_count <= expected_mix_q.size();
  end

endmodule

// ----- test/soft_hard_clip_distortion_tb.sv -----
// Testbench top for the clipping distortion: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module soft_hard_clip_distortion_tb;
  import shcd_pkg::*;

  localparam int SAMPLE_BITS     = 24;
  localparam int EXP_TABLE_DEPTH = 256;
  localparam int PIPE_LATENCY    = 9;
  localparam int CYCLE_LIMIT     = 400000;
  localparam int RANDOM_PHASES   = 10;
  localparam int PHASE_BEATS     = 93;
  localparam int CFG_SPARE_LO    = CFG_HARD_ENABLE + 1;
  localparam int CFG_SPARE_HI    = (1 << CFG_INDEX_W) - 1;

  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  logic                          clk;
  logic                          rst_n;
  logic                          start;
  logic                          busy;
  logic signed [SAMPLE_BITS-1:0] in_sample;
  logic                          out_valid;
  logic signed [SAMPLE_BITS-1:0] out_sample;
  logic                          cfg_wr_en;
  logic [CFG_INDEX_W-1:0]        cfg_index;
  logic [CFG_DATA_W-1:0]         cfg_wdata;

  int   fail_count;
  int   pending_count;
  int   cycle_count;
  logic no_gaps;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  soft_hard_clip_distortion #(
    .SAMPLE_BITS    (SAMPLE_BITS),
    .EXP_TABLE_DEPTH(EXP_TABLE_DEPTH)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_sample (in_sample),
    .out_valid (out_valid),
    .out_sample(out_sample),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  shcd_checker #(
    .SAMPLE_BITS    (SAMPLE_BITS),
    .EXP_TABLE_DEPTH(EXP_TABLE_DEPTH)
  ) mix_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_sample    (in_sample),
    .out_valid    (out_valid),
    .out_sample   (out_sample),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .fail_count   (fail_count),
    .pending_count(pending_count)
  );

  // Watchdog on the total run length; the counter starts from zero.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Offer one input beat, with random idle cycles ahead of it unless gaps are off.
  task automatic send_sample(logic signed [SAMPLE_BITS-1:0] value);
    if (!no_gaps) begin
      while ($urandom_range(99) < 28) begin
        start <= 1'b0;
        @(posedge clk);
      end
    end
    start     <= 1'b1;
    in_sample <= value;
    do @(posedge clk); while (busy);
  endtask

  // Stop sending and wait until every outstanding output beat has come back.
  task automatic drain_pipeline();
    start <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (PIPE_LATENCY + 2) @(posedge clk);
  endtask

  // The write enable stays high across back-to-back writes; the caller lowers it.
  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  // Write every register while idle, plus one write to an unused index.
  task automatic apply_settings(logic [CFG_DATA_W-1:0] pre, logic [CFG_DATA_W-1:0] drive,
                                logic [CFG_DATA_W-1:0] mix, logic [CFG_DATA_W-1:0] soft_on,
                                logic [CFG_DATA_W-1:0] hard_on);
    drain_pipeline();
    write_reg(CFG_PRE_GAIN, pre);
    write_reg(CFG_DRIVE_GAIN, drive);
    write_reg(CFG_WET_MIX, mix);
    write_reg(CFG_SOFT_ENABLE, soft_on);
    write_reg(CFG_HARD_ENABLE, hard_on);
    write_reg(CFG_INDEX_W'($urandom_range(CFG_SPARE_HI, CFG_SPARE_LO)),
              CFG_DATA_W'($urandom));
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic signed [SAMPLE_BITS-1:0] corner_sample(int k);
    case (k)
      0: return SAMPLE_MAX;
      1: return SAMPLE_MIN;
      2: return '0;
      3: return SAMPLE_BITS'(1);
      4: return SAMPLE_BITS'(-1);
      5: return SAMPLE_MAX >>> 1;
      6: return SAMPLE_MIN >>> 1;
      default: return SAMPLE_BITS'(256);
    endcase
  endfunction

  // Register value: often around a typical setting, else anywhere in range, an extreme or raw bits.
  function automatic logic [CFG_DATA_W-1:0] pick_value(int unsigned hi, int unsigned typical);
    int unsigned r;
    r = $urandom_range(9);
    if (r == 0) return '0;
    if (r == 1) return CFG_DATA_W'(hi);
    if (r == 2) return CFG_DATA_W'($urandom);
    if (r < 6) return CFG_DATA_W'($urandom_range(hi));
    return CFG_DATA_W'($urandom_range(typical * 2, typical / 2));
  endfunction

  // Full-scale noise, small signals of random size, and corner values.
  function automatic logic signed [SAMPLE_BITS-1:0] random_sample();
    int unsigned r;
    logic signed [SAMPLE_BITS-1:0] mag;
    r = $urandom_range(9);
    if (r < 4) return SAMPLE_BITS'($urandom);
    if (r < 8) begin
      mag = SAMPLE_BITS'($urandom >> $urandom_range(31, 8));
      return $urandom_range(1) ? -mag : mag;
    end
    return corner_sample($urandom_range(7));
  endfunction

  initial begin
    rst_n     <= 1'b0;
    start     <= 1'b0;
    in_sample <= '0;
    cfg_wr_en <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
    no_gaps   = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Register defaults after reset: both clippers on, half wet.
    for (int k = 0; k < 8; k++) send_sample(corner_sample(k));

    // Soft clip only, unity pregain, drive of 16, fully wet; the most negative
    // sample lands exactly on the end of the exponential table.
    apply_settings(4096, 4096, MIX_FULL, 1, 0);
    send_sample(SAMPLE_MIN);
    send_sample(SAMPLE_MAX);
    send_sample(corner_sample(5));

    // Hard clip only at maximum gains, with a wet fraction above one.
    apply_settings(65535, 32767, 131071, 0, 1);
    for (int k = 0; k < 5; k++) send_sample(corner_sample(k));

    // Both clippers off and fully wet: the mix must saturate.
    apply_settings(65535, 0, MIX_FULL, 0, 0);
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MIN);

    // Zero pregain and fully dry.
    apply_settings(0, 256, 0, 1, 1);
    send_sample(corner_sample(6));
    send_sample(SAMPLE_MAX);

    // Both clippers, a quarter wet.
    apply_settings(65535, 256, 16384, 1, 1);
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MIN);
    send_sample(corner_sample(7));

    // Random settings, each followed by a stretch of random beats.
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      apply_settings(pick_value(65535, 4096), pick_value(32767, 256),
                     pick_value(131071, 32768), CFG_DATA_W'($urandom),
                     CFG_DATA_W'($urandom));
      no_gaps = (ph == 2);
      for (int i = 0; i < PHASE_BEATS; i++) begin
        send_sample(random_sample());
        if (ph == 5 && i == PHASE_BEATS / 2) drain_pipeline();
      end
    end

    drain_pipeline();
    repeat (PIPE_LATENCY * 2) @(posedge clk);
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/shcd_pkg.sv
rtl/shcd_exp_interp.sv
rtl/soft_hard_clip_distortion.sv
test/shcd_checker.sv
test/soft_hard_clip_distortion_tb.sv
